### src/kls_pkg.sv
// ----------------------------------------------------------------------------
// kls_pkg
// Shared types and constants of the keyframe linear sampler.
// ----------------------------------------------------------------------------
package kls_pkg;

	localparam int CMD_W    = 2;
	localparam int KI_W     = 6;
	localparam int CI_W     = 4;
	localparam int TIME_W   = 32;
	localparam int VAL_W    = 32;
	localparam int KC_W     = 7;
	localparam int FRAC_W   = 17;   // Q0.16 plus one integer bit
	localparam int PROD_W   = 50;   // 33-bit magnitude times 17-bit fraction

	localparam int S_TDATA_W = 112;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 4;
	localparam int PADDR_W   = 3;

	localparam logic       REG_KEY_COUNT = 1'b0;
	localparam logic [6:0] KC_RESET      = 7'd1;

	typedef enum logic [1:0] {
		CMD_KEY_TIME  = 2'd0,
		CMD_KEY_VALUE = 2'd1,
		CMD_SAMPLE    = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TLAST,
		ST_TCHK,
		ST_SCAN,
		ST_DIV,
		ST_RDA,
		ST_RDB,
		ST_MUL,
		ST_ADD
	} state_t;

endpackage

### src/kls_ram.sv
// ----------------------------------------------------------------------------
// kls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/keyframe_linear_sampler_unit.sv
// ----------------------------------------------------------------------------
// keyframe_linear_sampler_unit
// Load beats are taken in the idle state, which the block does not leave for them.
// A sample beat runs through TLAST and TCHK, the serial key-time scan on the time
// RAM port (up to MAX_KEYS keys), the 17-step shift/subtract divider and
// two value RAM reads plus multiply and add per component. A sample past the
// last key skips the scan and the divider. Output stalls hold the block in ADD.
// Reset clears control state and sets key_count to 1; the key tables keep
// whatever they hold and are undefined until loaded.
// ----------------------------------------------------------------------------
module keyframe_linear_sampler_unit
	import kls_pkg::*;
#(
	parameter int MAX_KEYS   = 64,
	parameter int COMPONENTS = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// config port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// input stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// key_index[5:0], component_index[9:6], key_time[41:10],
	// key_value[73:42], sample_time[105:74], zero fill[111:106]
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// cmd[1:0]
	input  logic [CMD_W-1:0]     s_axis_tuser,
	// output stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// out_value[31:0]
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// out_component[3:0]
	output logic [M_TUSER_W-1:0] m_axis_tuser,
	output logic                 m_axis_tlast
);

	localparam int KW   = $clog2(MAX_KEYS);
	localparam int VD   = MAX_KEYS * COMPONENTS;
	localparam int VW   = $clog2(VD);
	localparam int KEXT = ((KW > KI_W) ? KW : KI_W) + 1;
	localparam int NW   = $clog2(MAX_KEYS + 1);
	localparam int CW   = (NW > KC_W) ? NW : KC_W;
	localparam logic [VW-1:0]   COMP_V  = VW'(COMPONENTS);
	localparam logic [CI_W-1:0] COMP_LAST = CI_W'(COMPONENTS - 1);

	// input fields
	logic [KI_W-1:0]   in_key_index;
	logic [CI_W-1:0]   in_comp_index;
	logic [TIME_W-1:0] in_key_time;
	logic [VAL_W-1:0]  in_key_value;
	logic [TIME_W-1:0] in_sample_time;
	cmd_t              in_cmd;

	assign in_key_index   = s_axis_tdata[5:0];
	assign in_comp_index  = s_axis_tdata[9:6];
	assign in_key_time    = s_axis_tdata[41:10];
	assign in_key_value   = s_axis_tdata[73:42];
	assign in_sample_time = s_axis_tdata[105:74];
	assign in_cmd         = cmd_t'(s_axis_tuser);

	// config
	logic [KC_W-1:0] kc_q;
	logic            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_KEY_COUNT) ? {25'd0, kc_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kc_q <= KC_RESET;
		end else if (cfg_wr && paddr[2] == REG_KEY_COUNT) begin
			kc_q <= pwdata[KC_W-1:0];
		end
	end

	logic [CW-1:0] kc_ext;
	logic [CW-1:0] n_eff;
	logic [KW-1:0] last_key;

	assign kc_ext   = CW'(kc_q);
	assign n_eff    = (kc_ext == '0) ? CW'(1) :
	                  (kc_ext > CW'(MAX_KEYS)) ? CW'(MAX_KEYS) : kc_ext;
	assign last_key = KW'(n_eff - CW'(1));

	// state and datapath registers
	state_t state_q, state_d;

	logic [TIME_W-1:0] t_q;
	logic [TIME_W-1:0] prev_q;
	logic [KW-1:0]     idx_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] den_q;
	logic [4:0]        cnt_q;
	logic [FRAC_W-1:0] frac_q;
	logic [VW-1:0]     addr_a_q;
	logic [VW-1:0]     addr_b_q;
	logic [CI_W-1:0]   comp_q;
	logic [VAL_W-1:0]  a_q;
	logic              neg_q;
	logic [PROD_W-1:0] prod_q;

	logic              m_valid_q;
	logic [VAL_W-1:0]  m_value_q;
	logic [CI_W-1:0]   m_comp_q;
	logic              m_last_q;

	// RAMs
	logic              accept;
	logic              ki_ok;
	logic              ci_ok;
	logic              t_we;
	logic              v_we;
	logic [KW-1:0]     t_waddr;
	logic [VW-1:0]     v_waddr;
	logic [KW-1:0]     t_raddr;
	logic [VW-1:0]     v_raddr;
	logic [TIME_W-1:0] t_rdata;
	logic [VAL_W-1:0]  v_rdata;

	assign accept  = s_axis_tvalid & s_axis_tready;
	assign ki_ok   = KEXT'(in_key_index) < KEXT'(MAX_KEYS);
	assign ci_ok   = {1'b0, in_comp_index} < 5'(COMPONENTS);
	assign t_we    = accept && in_cmd == CMD_KEY_TIME && ki_ok;
	assign v_we    = accept && in_cmd == CMD_KEY_VALUE && ki_ok && ci_ok;
	assign t_waddr = KW'(in_key_index);
	assign v_waddr = VW'(in_key_index) * COMP_V + VW'(in_comp_index);

	kls_ram #(
		.WIDTH (TIME_W),
		.DEPTH (MAX_KEYS)
	) u_time_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (in_key_time),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	kls_ram #(
		.WIDTH (VAL_W),
		.DEPTH (VD)
	) u_value_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (in_key_value),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	// scan / divide / lerp helpers
	logic              seg_hit;
	logic              past_last;
	logic [TIME_W:0]   div_sh;
	logic              div_ge;
	logic [TIME_W:0]   diff;
	logic [TIME_W:0]   mag;
	logic [VAL_W-1:0]  q_val;
	logic [VAL_W-1:0]  delta;
	logic              out_free;
	logic              out_load;
	logic [VW-1:0]     seg_base;

	assign past_last = t_q > t_rdata;
	assign seg_hit   = (idx_q != '0) && (prev_q < t_q) && (t_q <= t_rdata);
	assign div_sh    = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign div_ge    = div_sh >= {1'b0, den_q};
	assign diff      = {v_rdata[VAL_W-1], v_rdata} - {a_q[VAL_W-1], a_q};
	assign mag       = diff[TIME_W] ? (~diff + 1'b1) : diff;
	assign q_val     = prod_q[47:16];
	assign delta     = neg_q ? (~q_val + 1'b1) : q_val;
	assign out_free  = !m_valid_q || m_axis_tready;
	assign seg_base  = VW'(idx_q) * COMP_V;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		t_raddr       = idx_q;
		v_raddr       = addr_a_q;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && in_cmd == CMD_SAMPLE) begin
					state_d = ST_TLAST;
				end
			end
			ST_TLAST: begin
				t_raddr = last_key;
				state_d = ST_TCHK;
			end
			ST_TCHK: begin
				t_raddr = '0;
				state_d = past_last ? ST_RDA : ST_SCAN;
			end
			ST_SCAN: begin
				t_raddr = idx_q + 1'b1;
				if (seg_hit) begin
					state_d = ST_DIV;
				end else if (idx_q == last_key) begin
					state_d = ST_RDA;
				end
			end
			ST_DIV: begin
				if (cnt_q == 5'(FRAC_W - 1)) begin
					state_d = ST_RDA;
				end
			end
			ST_RDA: begin
				v_raddr = addr_a_q;
				state_d = ST_RDB;
			end
			ST_RDB: begin
				v_raddr = addr_b_q;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = (comp_q == COMP_LAST) ? ST_IDLE : ST_RDA;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				t_q <= in_sample_time;
			end
			ST_TCHK: begin
				idx_q    <= '0;
				comp_q   <= '0;
				frac_q   <= '0;
				// past the last key: emit key last unchanged
				addr_a_q <= VW'(last_key) * COMP_V;
				addr_b_q <= VW'(last_key) * COMP_V;
			end
			ST_SCAN: begin
				comp_q <= '0;
				if (seg_hit) begin
					rem_q    <= t_q - prev_q;
					den_q    <= t_rdata - prev_q;
					cnt_q    <= '0;
					addr_a_q <= seg_base - COMP_V;
					addr_b_q <= seg_base;
				end else if (idx_q == last_key) begin
					// at or before the first key, or no segment found
					frac_q   <= '0;
					addr_a_q <= '0;
					addr_b_q <= '0;
				end else begin
					prev_q <= t_rdata;
					idx_q  <= idx_q + 1'b1;
				end
			end
			ST_DIV: begin
				rem_q  <= div_ge ? TIME_W'(div_sh - {1'b0, den_q}) : div_sh[TIME_W-1:0];
				frac_q <= {frac_q[FRAC_W-2:0], div_ge};
				cnt_q  <= cnt_q + 1'b1;
			end
			ST_RDB: begin
				a_q <= v_rdata;
			end
			ST_MUL: begin
				neg_q  <= diff[TIME_W];
				prod_q <= PROD_W'(mag) * PROD_W'(frac_q);
			end
			ST_ADD: begin
				if (out_free) begin
					comp_q   <= comp_q + 1'b1;
					addr_a_q <= addr_a_q + 1'b1;
					addr_b_q <= addr_b_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_value_q <= a_q + delta;
			m_comp_q  <= comp_q;
			m_last_q  <= (comp_q == COMP_LAST);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_value_q;
	assign m_axis_tuser  = m_comp_q;
	assign m_axis_tlast  = m_last_q;

endmodule

### src/kls_checker.sv
// ----------------------------------------------------------------------------
// kls_checker
// Port-level checks of the keyframe linear sampler, bound to the top level.
// ----------------------------------------------------------------------------
module kls_checker
	import kls_pkg::*;
#(
	parameter int COMPONENTS = 11
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [CMD_W-1:0]     s_axis_tuser,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata,
	input logic [M_TUSER_W-1:0] m_axis_tuser,
	input logic                 m_axis_tlast
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// a sample beat makes the block busy
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_SAMPLE |=> !s_axis_tready)
		else $error("ready after sample beat");

	// a load beat leaves the block ready
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser != CMD_SAMPLE |=> s_axis_tready)
		else $error("not ready after load beat");

	a_comp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> {1'b0, m_axis_tuser} < 5'(COMPONENTS))
		else $error("component index out of range");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tlast == (m_axis_tuser == 4'(COMPONENTS - 1)))
		else $error("tlast not on final component");

endmodule

bind keyframe_linear_sampler_unit kls_checker #(.COMPONENTS(COMPONENTS)) u_kls_checker (.*);
